FILE: rtl/core/lrbp_pkg.sv
// Package: shared types, codes and the seven-segment table of the LED row buffer painter.
`default_nettype none

package lrbp_pkg;

    localparam int unsigned ROW_COUNT  = 8;
    localparam int unsigned ROW_W      = 3;

    typedef enum logic [1:0] {
        CMD_DIGIT = 2'd0,
        CMD_BAR   = 2'd1,
        CMD_RAW   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // bar column select codes
    localparam logic [1:0] SIDE_BIT4 = 2'd1;
    localparam logic [1:0] SIDE_BIT2 = 2'd2;

    // bar mode codes
    localparam logic [2:0] BAR_CLEAR   = 3'd0;
    localparam logic [2:0] BAR_MARK_LO = 3'd1;
    localparam logic [2:0] BAR_MARK_HI = 3'd3;
    localparam logic [2:0] BAR_SET     = 3'd4;

    localparam logic [7:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] digit_position;
        logic [3:0] digit_value;
        logic [1:0] bar_side;
        logic [2:0] bar_level;
        logic [2:0] bar_mode;
        logic [3:0] target_register;
        logic [7:0] write_value;
    } t_req;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       last;
    } t_res;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_row;
    } t_dp_stat;

    // segment pattern; bit k+1 goes to row k+1, digits above 9 blank
    function automatic logic [7:0] seg_pattern(input logic [3:0] value);
        logic [7:0] pat;
        case (value)
            4'd0:    pat = 8'h7e;
            4'd1:    pat = 8'h0c;
            4'd2:    pat = 8'hb6;
            4'd3:    pat = 8'h9e;
            4'd4:    pat = 8'hcc;
            4'd5:    pat = 8'hda;
            4'd6:    pat = 8'hfa;
            4'd7:    pat = 8'h0e;
            4'd8:    pat = 8'hfe;
            4'd9:    pat = 8'hde;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lrbp_ctrl.sv
// Controller: sequences one request over its row writes.
`default_nettype none

module lrbp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output lrbp_pkg::t_dp_cmd      o_cmd,
    input  wire lrbp_pkg::t_dp_stat i_stat
);

    lrbp_pkg::t_state r_state;
    lrbp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrbp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        busy       = 1'b0;
        case (r_state)
            lrbp_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = lrbp_pkg::ST_RUN;
                end
            end
            lrbp_pkg::ST_RUN: begin
                busy       = 1'b1;
                o_cmd.step = 1'b1;
                if (i_stat.last_row) begin
                    n_state = lrbp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/lrbp_datapath.sv
// Datapath: request register, row counter, frame buffer and write word register.
`default_nettype none

module lrbp_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lrbp_pkg::t_req     i_req,
    input  wire lrbp_pkg::t_dp_cmd  i_cmd,
    output lrbp_pkg::t_dp_stat      o_stat,
    output logic                    o_res_valid,
    output lrbp_pkg::t_res          o_res
);

    lrbp_pkg::t_req                r_req;
    logic [lrbp_pkg::ROW_W-1:0]    r_row;
    logic [7:0]                    r_buf [lrbp_pkg::ROW_COUNT];
    lrbp_pkg::t_res                r_res;
    logic                          r_res_valid;

    logic [7:0] row_cur;
    logic [7:0] row_new;
    logic [7:0] mask;
    logic [7:0] pattern;
    logic       bit_on;
    logic       bit_upd;
    logic       last_row;
    logic       buf_wr;
    lrbp_pkg::t_res n_res;

    assign row_cur = r_buf[r_row];
    assign pattern = lrbp_pkg::seg_pattern(r_req.digit_value);

    always_comb begin
        mask    = 8'h00;
        bit_on  = 1'b0;
        bit_upd = 1'b0;
        case (lrbp_pkg::t_cmd'(r_req.command))
            lrbp_pkg::CMD_DIGIT: begin
                if (r_req.digit_position <= 4'd1) begin
                    mask = 8'h01;
                end else if (r_req.digit_position <= 4'd8) begin
                    mask = 8'h01 << (r_req.digit_position[2:0] - 3'd1);
                end
                // pattern bit row+1; r_row stays below 7 here
                bit_on  = pattern[r_row + 3'd1];
                bit_upd = 1'b1;
            end
            lrbp_pkg::CMD_BAR: begin
                if (r_req.bar_side == lrbp_pkg::SIDE_BIT4) begin
                    mask = 8'h10;
                end else if (r_req.bar_side == lrbp_pkg::SIDE_BIT2) begin
                    mask = 8'h04;
                end else begin
                    mask = 8'h01;
                end
                case (r_req.bar_mode) inside
                    lrbp_pkg::BAR_CLEAR: begin
                        bit_upd = 1'b1;
                    end
                    [lrbp_pkg::BAR_MARK_LO:lrbp_pkg::BAR_MARK_HI]: begin
                        bit_on  = (r_row == r_req.bar_level);
                        bit_upd = 1'b1;
                    end
                    lrbp_pkg::BAR_SET: begin
                        bit_on  = 1'b1;
                        bit_upd = 1'b1;
                    end
                    default: begin
                        bit_upd = 1'b0;
                    end
                endcase
            end
            default: begin
                bit_upd = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (!bit_upd) begin
            row_new = row_cur;
        end else if (bit_on) begin
            row_new = row_cur | mask;
        end else begin
            row_new = row_cur & ~mask;
        end
    end

    always_comb begin
        case (lrbp_pkg::t_cmd'(r_req.command))
            lrbp_pkg::CMD_DIGIT: last_row = (r_row == 3'd6);
            lrbp_pkg::CMD_RAW:   last_row = 1'b1;
            default:             last_row = (r_row == 3'd7);
        endcase
    end

    assign buf_wr = i_cmd.step &&
                    (r_req.command == lrbp_pkg::CMD_DIGIT ||
                     r_req.command == lrbp_pkg::CMD_BAR);

    always_comb begin
        n_res.last        = last_row;
        n_res.reg_address = {1'b0, r_row} + 4'd1;
        n_res.reg_data    = row_new;
        case (lrbp_pkg::t_cmd'(r_req.command))
            lrbp_pkg::CMD_RAW: begin
                n_res.reg_address = r_req.target_register;
                n_res.reg_data    = r_req.write_value;
            end
            lrbp_pkg::CMD_CLEAR: begin
                n_res.reg_data = 8'h00;
            end
            default: begin
                n_res.reg_data = row_new;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.step) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < lrbp_pkg::ROW_COUNT; i++) begin
                r_buf[i] <= 8'h00;
            end
        end else begin
            r_res_valid <= i_cmd.step;
            if (i_cmd.load) begin
                r_row <= '0;
            end else if (i_cmd.step) begin
                r_row <= r_row + 3'd1;
            end
            if (buf_wr) begin
                r_buf[r_row] <= row_new;
            end
        end
    end

    assign o_stat.last_row = last_row;
    assign o_res_valid     = r_res_valid;
    assign o_res           = r_res;

endmodule

`default_nettype wire

FILE: rtl/core/led_row_buffer_painter.sv
// Top level: LED row buffer painter, controller plus datapath.
//
//  channel   signals                          handshake
//  -------   -------------------------------  -------------------------------
//  request   i_req (lrbp_pkg::t_req)          start high while busy low
//  result    o_res (lrbp_pkg::t_res)          o_res_valid, one-cycle strobe
//
// A request is taken at the edge where start is high and busy is low. It then
// runs one row per cycle: 7 rows for digit, 8 for bar and clear, 1 for raw,
// set by the single frame buffer read/write port and the row counter.
// Each write word is registered and appears in the cycle after its row is processed;
// the next request can be taken in the cycle after the last row.
// Reset (synchronous, active low) clears the frame buffer and the controller.
// The receiver cannot stall: each write word is shown for exactly one cycle.
`default_nettype none

module led_row_buffer_painter (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire lrbp_pkg::t_req  i_req,
    output logic                 o_res_valid,
    output lrbp_pkg::t_res       o_res
);

    lrbp_pkg::t_dp_cmd  dp_cmd;
    lrbp_pkg::t_dp_stat dp_stat;

    // sequencer: idle / run, steps one row per cycle
    lrbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // request latch, row buffer update and registered write word
    lrbp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // every busy cycle produces exactly one write word
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_res_valid)
        else $error("busy cycle produced no write word");

    // write words only come out of a running request
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("write word without running request");

    // final write of a request coincides with the controller going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("controller still busy after final write");

    // an accepted request starts running at once
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the LED row buffer painter: directed and random requests.
`timescale 1ns / 100ps

module tb;

    // Seven-segment patterns, digits 0 to 9; bit k+1 lights row k+1.
    localparam logic [7:0] SEG_DIGITS [10] = '{
        8'h7e, 8'h0c, 8'hb6, 8'h9e, 8'hcc, 8'hda, 8'hfa, 8'h0e, 8'hfe, 8'hde
    };
    localparam int DIGIT_ROWS   = 7;
    localparam int RANDOM_ITEMS = 256;
    localparam int REPORT_CAP   = 10;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    lrbp_pkg::t_req i_req;
    logic o_res_valid;
    lrbp_pkg::t_res o_res;

    // Shadow frame buffer and the write words still owed by the block.
    logic [7:0]     frame_shadow [lrbp_pkg::ROW_COUNT];
    lrbp_pkg::t_res pending_writes [$];
    int             mismatch_count;

    led_row_buffer_painter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // 20 ns clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Queue one expected write word.
    function automatic void owe_write(input logic [3:0] addr, input logic [7:0] data,
                                      input logic fin);
        lrbp_pkg::t_res w;
        w.reg_address = addr;
        w.reg_data    = data;
        w.last        = fin;
        pending_writes.push_back(w);
    endfunction

    // Apply an accepted request to the shadow buffer and queue its writes.
    function automatic void paint_rows(input lrbp_pkg::t_req r);
        logic [7:0] pattern;
        logic [7:0] mask;
        logic       lit;
        case (lrbp_pkg::t_cmd'(r.command))
            lrbp_pkg::CMD_DIGIT: begin
                pattern = (r.digit_value < 4'd10) ? SEG_DIGITS[r.digit_value] : 8'h00;
                if (r.digit_position <= 4'd1)
                    mask = 8'h01;
                else if (r.digit_position <= 4'd8)
                    mask = 8'h01 << (r.digit_position - 4'd1);
                else
                    mask = 8'h00;   // column off the edge: nothing painted
                for (int row = 0; row < DIGIT_ROWS; row++) begin
                    if (pattern[row + 1])
                        frame_shadow[row] = frame_shadow[row] | mask;
                    else
                        frame_shadow[row] = frame_shadow[row] & ~mask;
                    owe_write(4'(row + 1), frame_shadow[row], row == DIGIT_ROWS - 1);
                end
            end
            lrbp_pkg::CMD_BAR: begin
                if (r.bar_side == lrbp_pkg::SIDE_BIT4)
                    mask = 8'h10;
                else if (r.bar_side == lrbp_pkg::SIDE_BIT2)
                    mask = 8'h04;
                else
                    mask = 8'h01;
                for (int row = 0; row < lrbp_pkg::ROW_COUNT; row++) begin
                    if (r.bar_mode == lrbp_pkg::BAR_CLEAR) begin
                        frame_shadow[row] = frame_shadow[row] & ~mask;
                    end else if (r.bar_mode <= lrbp_pkg::BAR_MARK_HI) begin
                        lit = (row == int'(r.bar_level));
                        if (lit)
                            frame_shadow[row] = frame_shadow[row] | mask;
                        else
                            frame_shadow[row] = frame_shadow[row] & ~mask;
                    end else if (r.bar_mode == lrbp_pkg::BAR_SET) begin
                        frame_shadow[row] = frame_shadow[row] | mask;
                    end
                    owe_write(4'(row + 1), frame_shadow[row],
                              row == lrbp_pkg::ROW_COUNT - 1);
                end
            end
            lrbp_pkg::CMD_RAW: begin
                owe_write(r.target_register, r.write_value, 1'b1);
            end
            default: begin
                // clear writes zeros but leaves the buffer alone
                for (int row = 0; row < lrbp_pkg::ROW_COUNT; row++)
                    owe_write(4'(row + 1), 8'h00, row == lrbp_pkg::ROW_COUNT - 1);
            end
        endcase
    endfunction

    // Present one request from the falling edge until it is taken.
    // start is left high so a following request in the burst keeps it high.
    task automatic send_request(input lrbp_pkg::t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        paint_rows(r);
    endtask

    // Sender gap of the given number of cycles.
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    function automatic lrbp_pkg::t_req make_request(
        input lrbp_pkg::t_cmd cmd, input logic [3:0] pos,
        input logic [3:0] val, input logic [1:0] side,
        input logic [2:0] level, input logic [2:0] mode,
        input logic [3:0] addr, input logic [7:0] data);
        lrbp_pkg::t_req r;
        r.command         = cmd;
        r.digit_position  = pos;
        r.digit_value     = val;
        r.bar_side        = side;
        r.bar_level       = level;
        r.bar_mode        = mode;
        r.target_register = addr;
        r.write_value     = data;
        return r;
    endfunction

    // Fully random request; columns mostly on the panel.
    function automatic lrbp_pkg::t_req random_request();
        lrbp_pkg::t_req r;
        r = lrbp_pkg::t_req'(($bits(lrbp_pkg::t_req))'($urandom));
        if ($urandom_range(0, 99) < 85)
            r.digit_position = 4'($urandom_range(0, 8));
        return r;
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is taken.
    always @(posedge i_clk) begin
        lrbp_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (pending_writes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("unexpected write: addr %0d data %h last %b",
                             o_res.reg_address, o_res.reg_data, o_res.last);
            end else begin
                want = pending_writes.pop_front();
                if (o_res.reg_address !== want.reg_address ||
                    o_res.reg_data !== want.reg_data || o_res.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display({"write mismatch: exp addr %0d data %h last %b, ",
                                  "got addr %0d data %h last %b"},
                                 want.reg_address, want.reg_data, want.last,
                                 o_res.reg_address, o_res.reg_data, o_res.last);
                end
            end
        end
    end

    // Each digit at the column of its own number, plus blank digits and off-panel columns.
    task automatic test_digit_paint();
        for (int d = 0; d < 10; d++) begin
            send_request(make_request(lrbp_pkg::CMD_DIGIT, 4'(d), 4'(d), 2'd3, 3'd7, 3'd7,
                                      4'hf, 8'hff));
            hold_off($urandom_range(0, 2));
        end
        // blank digits, then a column off the edge
        send_request(make_request(lrbp_pkg::CMD_DIGIT, 4'd5, 4'd10, 2'd0, 3'd0, 3'd0,
                                  4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_DIGIT, 4'd8, 4'd15, 2'd0, 3'd0, 3'd0,
                                  4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_DIGIT, 4'd15, 4'd8, 2'd0, 3'd0, 3'd0,
                                  4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_DIGIT, 4'd9, 4'd0, 2'd0, 3'd0, 3'd0,
                                  4'h0, 8'h00));
    endtask

    // Each bar mode class across the column selects, levels at both ends.
    task automatic test_bar_paint();
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, lrbp_pkg::SIDE_BIT4, 3'd0,
                                  lrbp_pkg::BAR_SET, 4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, lrbp_pkg::SIDE_BIT2, 3'd0,
                                  lrbp_pkg::BAR_MARK_LO, 4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'hf, 4'hf, lrbp_pkg::SIDE_BIT2, 3'd7,
                                  3'd2, 4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, 2'd0, 3'd7,
                                  lrbp_pkg::BAR_MARK_HI, 4'h0, 8'h00));
        hold_off(1);
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, 2'd3, 3'd5, 3'd5,
                                  4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, lrbp_pkg::SIDE_BIT4, 3'd2,
                                  3'd7, 4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, lrbp_pkg::SIDE_BIT4, 3'd0,
                                  lrbp_pkg::BAR_CLEAR, 4'h0, 8'h00));
    endtask

    task automatic test_raw_write();
        send_request(make_request(lrbp_pkg::CMD_RAW, 4'hf, 4'hf, 2'd3, 3'd7, 3'd7,
                                  4'h0, 8'h00));
        send_request(make_request(lrbp_pkg::CMD_RAW, 4'h0, 4'h0, 2'd0, 3'd0, 3'd0,
                                  4'hf, 8'hff));
    endtask

    task automatic test_clear();
        send_request(make_request(lrbp_pkg::CMD_CLEAR, 4'h3, 4'h8, 2'd1, 3'd3, 3'd4,
                                  4'h9, 8'h5a));
        // buffer must survive the clear
        send_request(make_request(lrbp_pkg::CMD_BAR, 4'h0, 4'h0, 2'd0, 3'd0, 3'd6,
                                  4'h0, 8'h00));
    endtask

    // Sender stops until every owed write has come back.
    task automatic drain_writes();
        hold_off(1);
        while (pending_writes.size() != 0)
            @(posedge i_clk);
    endtask

    // Random requests in bursts with random gaps; one full drain midway.
    task automatic test_random_mix();
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_writes();
            if (burst_left == 0) begin
                hold_off($urandom_range(0, 6));
                burst_left = $urandom_range(1, 14);
            end
            send_request(random_request());
            burst_left--;
        end
        hold_off(1);
    endtask

    // Sequence: reset, directed requests, random requests, drain, verdict.
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        mismatch_count = 0;
        for (int row = 0; row < lrbp_pkg::ROW_COUNT; row++)
            frame_shadow[row] = 8'h00;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_digit_paint();
        test_bar_paint();
        test_raw_write();
        test_clear();
        drain_writes();
        test_random_mix();

        drain_writes();
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0 && pending_writes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
